@@ src/grdda_pkg.sv @@
package grdda_pkg;

    localparam int MAP_SIZE  = 64;
    localparam int FRAC_BITS = 16;
    localparam int CW        = $clog2(MAP_SIZE);
    localparam int AW        = 2 * CW;
    localparam int DW        = 19;
    localparam int MW        = DW - 1;
    localparam int PW        = 22;
    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    localparam logic [7:0] CODE_WALL = 8'h31;
    localparam logic [7:0] CODE_T1   = 8'h35;
    localparam logic [7:0] CODE_T2   = 8'h36;
    localparam logic [7:0] CODE_T3   = 8'h37;
    localparam logic [7:0] CODE_T4   = 8'h38;

    // controller -> datapath commands
    typedef struct packed {
        logic load;       // capture item, start operand setup
        logic sqrt_step;  // one root digit
        logic div_init;   // start the divide for one axis
        logic div_step;   // one quotient bit
        logic div_done;   // store delta for current axis
        logic mul_x;      // side init x
        logic mul_y;      // side init y
        logic walk_step;  // take one DDA step, issue map read
        logic check;      // look at the map byte
        logic axis;       // current divide axis (0 = x)
    } grdda_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic off_start;
        logic off_step;   // last step left the map
        logic is_wall;
    } grdda_sts_t;

    function automatic logic [2:0] trap_of(input logic [7:0] c);
        logic [2:0] t;
        case (c)
            CODE_T1: t = 3'd1;
            CODE_T2: t = 3'd2;
            CODE_T3: t = 3'd3;
            CODE_T4: t = 3'd4;
            default: t = 3'd0;
        endcase
        return t;
    endfunction

endpackage

@@ src/grdda_ctrl.sv @@
module grdda_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   mode,
    output logic                   busy,
    output logic                   done,
    output grdda_pkg::grdda_cmd_t  cmd,
    input  grdda_pkg::grdda_sts_t  sts
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SQRT = 8'b0000_0010,
        S_DIVI = 8'b0000_0100,
        S_DIV  = 8'b0000_1000,
        S_MUL  = 8'b0001_0000,
        S_STEP = 8'b0010_0000,
        S_CHK  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic       axis_reg, axis_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        axis_next  = axis_reg;
        cmd        = '0;
        cmd.axis   = axis_reg;
        done       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start && mode)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SQRT;
                    cnt_next   = '0;
                end
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 6'd1;
                if (cnt_reg == 6'd18)
                begin
                    state_next = S_DIVI;
                    axis_next  = 1'b0;
                end
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                // 35 quotient bits, then store
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 6'd1;
                if (cnt_reg == 6'd35)
                begin
                    cmd.div_step = 1'b0;
                    cmd.div_done = 1'b1;
                    if (axis_reg)
                    begin
                        state_next = S_MUL;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        axis_next  = 1'b1;
                        state_next = S_DIVI;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul_x = (cnt_reg == 6'd0);
                cmd.mul_y = (cnt_reg == 6'd1);
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == 6'd1)
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                if (sts.off_start)
                    state_next = S_DONE;
                else
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = S_CHK;
                end
            end
            S_CHK:
            begin
                if (sts.off_step)
                    state_next = S_DONE;
                else
                begin
                    cmd.check = 1'b1;
                    state_next = sts.is_wall ? S_DONE : S_STEP;
                end
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            axis_reg  <= axis_next;
        end
    end

endmodule

@@ src/grdda_datapath.sv @@
module grdda_datapath
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [5:0]             cell_x,
    input  logic [5:0]             cell_y,
    input  logic [7:0]             cell_code,
    input  logic [21:0]            pos_x,
    input  logic [21:0]            pos_y,
    input  logic [18:0]            dir_x,
    input  logic [18:0]            dir_y,
    input  grdda_pkg::grdda_cmd_t  cmd,
    output grdda_pkg::grdda_sts_t  sts,
    output logic [5:0]             hit_x,
    output logic [5:0]             hit_y,
    output logic                   hit_side,
    output logic [2:0]             trap_kind,
    output logic                   step_x_negative,
    output logic                   step_y_negative,
    output logic [31:0]            side_dist_x,
    output logic [31:0]            side_dist_y,
    output logic [31:0]            delta_dist_x,
    output logic [31:0]            delta_dist_y,
    output logic                   off_map
);

    localparam int CW = grdda_pkg::CW;
    localparam int MW = grdda_pkg::MW;
    localparam int F  = grdda_pkg::FRAC_BITS;
    localparam int SQW = 2 * MW + 2;          // a^2+b^2 width
    localparam int RW  = MW + 1;              // root width
    localparam int NW  = RW + F;              // dividend width

    // map store; reset to empty by valid bits is too costly, so clear by pass
    logic [7:0]      mem [grdda_pkg::MAP_SIZE * grdda_pkg::MAP_SIZE];
    logic [7:0]      rd_reg;
    logic [2*CW:0]   clr_reg;                  // clear pointer, top bit = done
    logic            clearing;

    logic [5:0]      cx_reg, cy_reg;
    logic [21:0]     px_reg, py_reg;
    logic            nx_reg, ny_reg;
    logic [MW:0]     ax_reg, ay_reg;
    logic [SQW-1:0]  sq_reg, rem_reg;
    logic [RW-1:0]   root_reg;
    logic [NW-1:0]   num_reg;
    logic [MW+1:0]   drem_reg;
    logic [NW-1:0]   quo_reg;
    logic [31:0]     ddx_reg, ddy_reg, sdx_reg, sdy_reg;
    logic [5:0]      x_reg, y_reg;
    logic            side_reg, off_reg;
    logic [2:0]      trap_reg;

    logic [MW:0]     abs_dx, abs_dy;

    assign clearing = !clr_reg[2*CW];

    assign abs_dx = dir_x[18] ? 19'(-dir_x) : dir_x;
    assign abs_dy = dir_y[18] ? 19'(-dir_y) : dir_y;

    // one restoring root digit per cycle
    logic [SQW+1:0] trial;
    logic [SQW+1:0] rem_sh;
    always_comb
    begin
        rem_sh = {rem_reg, sq_reg[SQW-1 -: 2]};
        trial  = {{(SQW+2-RW-2){1'b0}}, root_reg, 2'b01};
    end

    // restoring divide of root<<F by a
    logic [MW:0]   dsr;
    logic [MW+1:0] dsh;
    assign dsr = cmd.axis ? ay_reg : ax_reg;
    assign dsh = {drem_reg[MW:0], num_reg[NW-1]};

    // side init operands
    logic [22:0] gap;
    logic [54:0] prod;
    logic [31:0] sat_prod;
    always_comb
    begin
        logic [22:0] lo, hi;
        logic        nn;
        logic [5:0]  c;
        logic [21:0] p;
        logic [31:0] d;
        nn = cmd.mul_x ? nx_reg : ny_reg;
        c  = cmd.mul_x ? cx_reg : cy_reg;
        p  = cmd.mul_x ? px_reg : py_reg;
        d  = cmd.mul_x ? ddx_reg : ddy_reg;
        lo = {1'b0, c, 16'd0};
        hi = {1'b0, c, 16'd0} + 23'h10000;
        if (nn)
            gap = ({1'b0, p} > lo) ? ({1'b0, p} - lo) : 23'd0;
        else
            gap = (hi > {1'b0, p}) ? (hi - {1'b0, p}) : 23'd0;
        prod = {32'd0, gap} * {23'd0, d};
        sat_prod = (|prod[54:48]) ? grdda_pkg::SAT32 : prod[47:16];
    end

    // DDA step
    logic        go_x;
    logic [32:0] sum_x, sum_y;
    logic [6:0]  tx, ty;
    logic        t_off;
    always_comb
    begin
        go_x  = sdx_reg < sdy_reg;
        sum_x = {1'b0, sdx_reg} + {1'b0, ddx_reg};
        sum_y = {1'b0, sdy_reg} + {1'b0, ddy_reg};
        tx = {1'b0, x_reg};
        ty = {1'b0, y_reg};
        if (go_x)
            tx = nx_reg ? tx - 7'd1 : tx + 7'd1;
        else
            ty = ny_reg ? ty - 7'd1 : ty + 7'd1;
        t_off = tx[6] || ty[6];
    end

    assign sts.off_start = 1'b0;
    assign sts.off_step  = off_reg;
    assign sts.is_wall   = (rd_reg == grdda_pkg::CODE_WALL) ||
                           (grdda_pkg::trap_of(rd_reg) != 3'd0);

    // clear pass and map writes; read the cell that the step is about to enter
    always_ff @(posedge clk)
    begin
        if (clearing)
            mem[clr_reg[2*CW-1:0]] <= 8'd0;
        else if (wr_en)
            mem[{cell_x, cell_y}] <= cell_code;
        rd_reg <= mem[{tx[5:0], ty[5:0]}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (clearing)
            clr_reg <= clr_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg   <= cell_x;
            cy_reg   <= cell_y;
            x_reg    <= cell_x;
            y_reg    <= cell_y;
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            nx_reg   <= dir_x[18];
            ny_reg   <= dir_y[18];
            ax_reg   <= abs_dx;
            ay_reg   <= abs_dy;
            sq_reg   <= ({{(SQW-RW){1'b0}}, abs_dx} * {{(SQW-RW){1'b0}}, abs_dx})
                      + ({{(SQW-RW){1'b0}}, abs_dy} * {{(SQW-RW){1'b0}}, abs_dy});
            rem_reg  <= '0;
            root_reg <= '0;
            side_reg <= 1'b0;
            off_reg  <= 1'b0;
            trap_reg <= 3'd0;
        end
        if (cmd.sqrt_step)
        begin
            sq_reg <= sq_reg << 2;
            if (rem_sh >= trial)
            begin
                rem_reg  <= SQW'(rem_sh - trial);
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= SQW'(rem_sh);
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
        if (cmd.div_init)
        begin
            num_reg  <= {root_reg, {F{1'b0}}};
            drem_reg <= '0;
            quo_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            num_reg <= num_reg << 1;
            if (dsh >= {1'b0, dsr})
            begin
                drem_reg <= dsh - {1'b0, dsr};
                quo_reg  <= {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= dsh;
                quo_reg  <= {quo_reg[NW-2:0], 1'b0};
            end
        end
        if (cmd.div_done)
        begin
            if (cmd.axis)
                ddy_reg <= (dsr == '0 || (|quo_reg[NW-1:32])) ? grdda_pkg::SAT32
                                                               : quo_reg[31:0];
            else
                ddx_reg <= (dsr == '0 || (|quo_reg[NW-1:32])) ? grdda_pkg::SAT32
                                                               : quo_reg[31:0];
        end
        if (cmd.mul_x)
            sdx_reg <= sat_prod;
        if (cmd.mul_y)
            sdy_reg <= sat_prod;
        if (cmd.walk_step)
        begin
            side_reg <= !go_x;
            if (go_x)
                sdx_reg <= sum_x[32] ? grdda_pkg::SAT32 : sum_x[31:0];
            else
                sdy_reg <= sum_y[32] ? grdda_pkg::SAT32 : sum_y[31:0];
            if (t_off)
                off_reg <= 1'b1;
            else
            begin
                x_reg <= tx[5:0];
                y_reg <= ty[5:0];
            end
        end
        if (cmd.check)
            trap_reg <= grdda_pkg::trap_of(rd_reg);
    end

    assign hit_x           = x_reg;
    assign hit_y           = y_reg;
    assign hit_side        = side_reg;
    assign trap_kind       = trap_reg;
    assign step_x_negative = nx_reg;
    assign step_y_negative = ny_reg;
    assign side_dist_x     = sdx_reg;
    assign side_dist_y     = sdy_reg;
    assign delta_dist_x    = ddx_reg;
    assign delta_dist_y    = ddy_reg;
    assign off_map         = off_reg;

endmodule

@@ src/grid_ray_dda_traversal_unit.sv @@
// Grid raycaster, DDA stepping over a 64x64 map of cell bytes.
//
// Command port: an item is taken at a clock edge with start high and busy
// low. mode 0 writes cell_code into the map at (cell_x, cell_y) and gives
// no result; busy stays low, so writes can follow back to back.
// mode 1 casts a ray from pos_x/pos_y along dir_x/dir_y starting in cell
// (cell_x, cell_y).
// A cast first sets up its operands (19 root digits, two 35-bit restoring
// divides, each after a load step, two side multiplies) and then walks
// cell steps, each a step followed by a check of the registered map read.
// done is high in S_DONE, which follows the check of the last step; at
// most 127 steps fit on the map.
// The result shows on the result ports with done high for one cycle; the
// receiver cannot stall, so nothing is held back.
// After reset the map is cleared by a pass over all 4096 cells, one cell per
// cycle; busy stays high during that pass.
module grid_ray_dda_traversal_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [5:0]  cell_x,
    input  logic [5:0]  cell_y,
    input  logic [7:0]  cell_code,
    input  logic [21:0] pos_x,
    input  logic [21:0] pos_y,
    input  logic [18:0] dir_x,
    input  logic [18:0] dir_y,
    output logic        done,
    output logic [5:0]  hit_x,
    output logic [5:0]  hit_y,
    output logic        hit_side,
    output logic [2:0]  trap_kind,
    output logic        step_x_negative,
    output logic        step_y_negative,
    output logic [31:0] side_dist_x,
    output logic [31:0] side_dist_y,
    output logic [31:0] delta_dist_x,
    output logic [31:0] delta_dist_y,
    output logic        off_map
);

    grdda_pkg::grdda_cmd_t cmd;
    grdda_pkg::grdda_sts_t sts;
    logic ctrl_busy;
    logic clr_busy;
    logic [12:0] clr_cnt_reg;

    // mirror of the datapath clear pass, hold busy until it ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (!clr_cnt_reg[12])
            clr_cnt_reg <= clr_cnt_reg + 13'd1;
    end
    assign clr_busy = !clr_cnt_reg[12];

    assign busy = ctrl_busy || clr_busy;

    grdda_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start && !clr_busy),
        .mode  (mode),
        .busy  (ctrl_busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    grdda_datapath u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr_en           (start && !busy && !mode),
        .cell_x          (cell_x),
        .cell_y          (cell_y),
        .cell_code       (cell_code),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .dir_x           (dir_x),
        .dir_y           (dir_y),
        .cmd             (cmd),
        .sts             (sts),
        .hit_x           (hit_x),
        .hit_y           (hit_y),
        .hit_side        (hit_side),
        .trap_kind       (trap_kind),
        .step_x_negative (step_x_negative),
        .step_y_negative (step_y_negative),
        .side_dist_x     (side_dist_x),
        .side_dist_y     (side_dist_y),
        .delta_dist_x    (delta_dist_x),
        .delta_dist_y    (delta_dist_y),
        .off_map         (off_map)
    );

endmodule

@@ test/grdda_checker.sv @@
`timescale 1ns / 100ps

// Watches the command and result channels of the raycaster, keeps its own
// copy of the map, predicts each cast and compares the results field by field.
module grdda_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        mode,
    input  logic [5:0]  cell_x,
    input  logic [5:0]  cell_y,
    input  logic [7:0]  cell_code,
    input  logic [21:0] pos_x,
    input  logic [21:0] pos_y,
    input  logic [18:0] dir_x,
    input  logic [18:0] dir_y,
    input  logic        done,
    input  logic [5:0]  hit_x,
    input  logic [5:0]  hit_y,
    input  logic        hit_side,
    input  logic [2:0]  trap_kind,
    input  logic        step_x_negative,
    input  logic        step_y_negative,
    input  logic [31:0] side_dist_x,
    input  logic [31:0] side_dist_y,
    input  logic [31:0] delta_dist_x,
    input  logic [31:0] delta_dist_y,
    input  logic        off_map,
    output int          fail_count,
    output int          pending,
    output int          off_map_count,
    output int          trap_count,
    output int          wall_count
);

    typedef struct {
        logic [5:0]  hx;
        logic [5:0]  hy;
        logic        side;
        logic [2:0]  trap;
        logic        nx;
        logic        ny;
        logic [31:0] sdx;
        logic [31:0] sdy;
        logic [31:0] ddx;
        logic [31:0] ddy;
        logic        off;
    } ray_hit_t;

    localparam logic [63:0] LIM = 64'hFFFF_FFFF;
    localparam int MSZ = grdda_pkg::MAP_SIZE;
    localparam int FB  = grdda_pkg::FRAC_BITS;

    logic [7:0] map_copy [MSZ*MSZ];
    ray_hit_t   expected_hits [$];

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] axis_delta(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        if (a == 0)
            return LIM;
        q = (root_floor(a * a + b * b) << FB) / a;
        return (q > LIM) ? LIM : q;
    endfunction

    function automatic logic [63:0] first_side(input logic neg, input logic [63:0] cell_idx,
                                               input logic [63:0] pos, input logic [63:0] d);
        longint gap;
        logic [63:0] p;
        if (neg)
            gap = longint'(pos) - longint'(cell_idx << FB);
        else
            gap = longint'((cell_idx + 1) << FB) - longint'(pos);
        if (gap < 0)
            gap = 0;
        p = (64'(gap) * d) >> FB;
        return (p > LIM) ? LIM : p;
    endfunction

    function automatic logic [63:0] add_clip(input logic [63:0] a, input logic [63:0] b);
        return (a + b > LIM) ? LIM : a + b;
    endfunction

    // Walk the ray over the local map copy.
    function automatic ray_hit_t cast_ray(input logic [5:0] cx, input logic [5:0] cy,
                                          input logic [21:0] px, input logic [21:0] py,
                                          input logic [18:0] dx, input logic [18:0] dy);
        ray_hit_t   h;
        longint     sx, sy, x, y, tx, ty;
        logic [63:0] ax, ay, ddx, ddy, sdx, sdy;
        logic [7:0] c;
        h.nx = dx[18];
        h.ny = dy[18];
        sx = {{45{dx[18]}}, dx};
        sy = {{45{dy[18]}}, dy};
        ax = 64'(h.nx ? -sx : sx);
        ay = 64'(h.ny ? -sy : sy);
        ddx = axis_delta(ax, ay);
        ddy = axis_delta(ay, ax);
        sdx = first_side(h.nx, cx, px, ddx);
        sdy = first_side(h.ny, cy, py, ddy);
        x = cx;
        y = cy;
        h.side = 0;
        h.trap = 0;
        h.off = 0;
        while (1)
        begin
            tx = x;
            ty = y;
            if (sdx < sdy)
            begin
                sdx = add_clip(sdx, ddx);
                tx = tx + (h.nx ? -1 : 1);
                h.side = 0;
            end
            else
            begin
                sdy = add_clip(sdy, ddy);
                ty = ty + (h.ny ? -1 : 1);
                h.side = 1;
            end
            if (tx < 0 || tx >= MSZ || ty < 0 || ty >= MSZ)
            begin
                h.off = 1;
                h.trap = 0;
                break;
            end
            x = tx;
            y = ty;
            c = map_copy[x * MSZ + y];
            case (c)
                grdda_pkg::CODE_T1: h.trap = 3'd1;
                grdda_pkg::CODE_T2: h.trap = 3'd2;
                grdda_pkg::CODE_T3: h.trap = 3'd3;
                grdda_pkg::CODE_T4: h.trap = 3'd4;
                default: h.trap = 3'd0;
            endcase
            if (c == grdda_pkg::CODE_WALL || h.trap != 0)
                break;
        end
        h.hx = x[5:0];
        h.hy = y[5:0];
        h.sdx = sdx[31:0];
        h.sdy = sdy[31:0];
        h.ddx = ddx[31:0];
        h.ddy = ddy[31:0];
        return h;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
        off_map_count = 0;
        trap_count = 0;
        wall_count = 0;
        foreach (map_copy[i])
            map_copy[i] = 8'h00;
    end

    always @(posedge clk)
    begin
        ray_hit_t e;
        if (rst_n)
        begin
            // result channel first: a result never belongs to an item taken this edge
            if (done)
            begin
                if (expected_hits.size() == 0)
                begin
                    $error("result with no cast outstanding");
                    fail_count++;
                end
                else
                begin
                    e = expected_hits.pop_front();
                    compare_field("hit_x", e.hx, hit_x);
                    compare_field("hit_y", e.hy, hit_y);
                    compare_field("hit_side", e.side, hit_side);
                    compare_field("trap_kind", e.trap, trap_kind);
                    compare_field("step_x_negative", e.nx, step_x_negative);
                    compare_field("step_y_negative", e.ny, step_y_negative);
                    compare_field("side_dist_x", e.sdx, side_dist_x);
                    compare_field("side_dist_y", e.sdy, side_dist_y);
                    compare_field("delta_dist_x", e.ddx, delta_dist_x);
                    compare_field("delta_dist_y", e.ddy, delta_dist_y);
                    compare_field("off_map", e.off, off_map);
                    if (e.off)
                        off_map_count++;
                    else if (e.trap != 0)
                        trap_count++;
                    else
                        wall_count++;
                end
            end
            if (start && !busy)
            begin
                if (!mode)
                    map_copy[cell_x * MSZ + cell_y] = cell_code;
                else
                    expected_hits.push_back(cast_ray(cell_x, cell_y, pos_x, pos_y,
                                                     dir_x, dir_y));
            end
            pending = expected_hits.size();
        end
    end

endmodule

@@ test/grid_ray_dda_traversal_unit_tb.sv @@
`timescale 1ns / 100ps

// Stimulus and verdict for the raycaster. The checker beside the block does
// all prediction and comparison; this module only feeds items and waits.
module grid_ray_dda_traversal_unit_tb;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        mode;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic [7:0]  cell_code;
    logic [21:0] pos_x;
    logic [21:0] pos_y;
    logic [18:0] dir_x;
    logic [18:0] dir_y;
    logic        done;
    logic [5:0]  hit_x;
    logic [5:0]  hit_y;
    logic        hit_side;
    logic [2:0]  trap_kind;
    logic        step_x_negative;
    logic        step_y_negative;
    logic [31:0] side_dist_x;
    logic [31:0] side_dist_y;
    logic [31:0] delta_dist_x;
    logic [31:0] delta_dist_y;
    logic        off_map;

    int fail_count;
    int pending;
    int off_map_count;
    int trap_count;
    int wall_count;
    int write_count;
    int cast_count;
    int idle_pct;

    grid_ray_dda_traversal_unit DUT (.*);

    grdda_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: covers the map clearing pass plus the slowest possible casts.
    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // Present one item at this edge and hold it until the block takes it.
    // Leaves the caller just after the accepting edge, start still high unless a random sender gap dropped it.
    task automatic send_item(input logic m, input logic [5:0] cx, input logic [5:0] cy,
                             input logic [7:0] code, input logic [21:0] px,
                             input logic [21:0] py, input logic [18:0] dx,
                             input logic [18:0] dy);
        start     <= 1'b1;
        mode      <= m;
        cell_x    <= cx;
        cell_y    <= cy;
        cell_code <= code;
        pos_x     <= px;
        pos_y     <= py;
        dir_x     <= dx;
        dir_y     <= dy;
        // sample busy mid-cycle so the edge decision is race free
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
        end
        @(posedge clk);
        if (m)
            cast_count++;
        else
            write_count++;
        // random sender gap: drop start and wait at random before the next item
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic put_cell(input logic [5:0] cx, input logic [5:0] cy, input logic [7:0] code);
        send_item(1'b0, cx, cy, code, 22'($urandom), 22'($urandom), 19'($urandom),
                  19'($urandom));
    endtask

    task automatic shoot(input logic [5:0] cx, input logic [5:0] cy, input logic [21:0] px,
                         input logic [21:0] py, input logic [18:0] dx, input logic [18:0] dy);
        send_item(1'b1, cx, cy, 8'($urandom), px, py, dx, dy);
    endtask

    // Cells mostly in a small corner so rays meet walls often.
    function automatic logic [5:0] pick_cell();
        return ($urandom_range(99) < 60) ? 6'($urandom_range(15)) : 6'($urandom);
    endfunction

    function automatic logic [18:0] pick_dir();
        int k;
        k = $urandom_range(99);
        if (k < 12)
            return 19'd0;
        else if (k < 18)
            return 19'h40000;   // most negative
        else if (k < 24)
            return 19'h3FFFF;   // most positive
        else if (k < 32)
            return 19'($urandom_range(1, 40)) ^ {19{1'($urandom_range(1))}};
        else
            return 19'($urandom);
    endfunction

    function automatic logic [21:0] pick_pos(input logic [5:0] c);
        if ($urandom_range(99) < 85)
            return {c, 16'($urandom)};
        return 22'($urandom);
    endfunction

    initial
    begin
        logic [5:0]  cx;
        logic [5:0]  cy;
        logic [7:0]  code;
        logic [18:0] dx;
        logic [18:0] dy;
        int          n;
        int          k;
        int          waited;

        rst_n     <= 1'b0;
        start     <= 1'b0;
        mode      <= 1'b0;
        cell_x    <= '0;
        cell_y    <= '0;
        cell_code <= '0;
        pos_x     <= '0;
        pos_y     <= '0;
        dir_x     <= '0;
        dir_y     <= '0;
        write_count = 0;
        cast_count  = 0;
        idle_pct    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every wall and trap code plus two plain bytes.
        put_cell(6'd12, 6'd10, grdda_pkg::CODE_WALL);
        put_cell(6'd10, 6'd13, grdda_pkg::CODE_T1);
        put_cell(6'd8,  6'd10, grdda_pkg::CODE_T2);
        put_cell(6'd10, 6'd7,  grdda_pkg::CODE_T3);
        put_cell(6'd11, 6'd11, grdda_pkg::CODE_T4);
        put_cell(6'd10, 6'd10, grdda_pkg::CODE_WALL);  // start cell holds a wall: must be skipped
        put_cell(6'd63, 6'd63, 8'hFF);
        put_cell(6'd0,  6'd0,  8'h00);
        // axis rays and one diagonal ray from the cell with a wall in it
        shoot(6'd10, 6'd10, {6'd10, 16'h8000}, {6'd10, 16'h8000}, 19'h10000, 19'd0);
        shoot(6'd10, 6'd10, {6'd10, 16'h8000}, {6'd10, 16'h8000}, 19'd0, 19'h10000);
        shoot(6'd10, 6'd10, {6'd10, 16'h8000}, {6'd10, 16'h8000}, 19'h70000, 19'd0);
        shoot(6'd10, 6'd10, {6'd10, 16'h8000}, {6'd10, 16'h8000}, 19'd0, 19'h70000);
        shoot(6'd10, 6'd10, {6'd10, 16'h4000}, {6'd10, 16'h4000}, 19'h10000, 19'h10000);
        // zero direction: both deltas saturate, walk goes along y
        shoot(6'd5, 6'd5, {6'd5, 16'h0}, {6'd5, 16'h0}, 19'd0, 19'd0);
        // extreme directions from corners; the first two leave the map at once
        shoot(6'd0, 6'd0, 22'd0, 22'd0, 19'h40000, 19'h40000);
        shoot(6'd63, 6'd63, 22'h3FFFFF, 22'h3FFFFF, 19'h3FFFF, 19'h3FFFF);
        shoot(6'd0, 6'd63, 22'd0, 22'h3FFFFF, 19'h3FFFF, 19'h40000);
        // position outside the start cell: gap clamps to zero
        shoot(6'd20, 6'd20, 22'h3FFFFF, 22'd0, 19'h00001, 19'h7FFFF);
        shoot(6'd20, 6'd20, 22'd0, 22'h3FFFFF, 19'h7FFFF, 19'h00001);
        // a tiny x component pushes delta_dist_x into saturation
        shoot(6'd30, 6'd2, {6'd30, 16'hFFFF}, {6'd2, 16'h0001}, 19'h00001, 19'h3FFFF);

        // Random part in four sender pacing phases.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: idle_pct = 0;
                1: idle_pct = 73;
                2: idle_pct = 0;
                default: idle_pct = 34;
            endcase
            n = 132;
            for (int i = 0; i < n; i++)
            begin
                cx = pick_cell();
                cy = pick_cell();
                if ($urandom_range(99) < 30)
                begin
                    k = $urandom_range(99);
                    if (k < 40)
                        code = grdda_pkg::CODE_WALL;
                    else if (k < 60)
                        code = 8'(grdda_pkg::CODE_T1 + $urandom_range(3));
                    else if (k < 70)
                        code = 8'h00;      // erase
                    else
                        code = 8'($urandom);
                    put_cell(cx, cy, code);
                end
                else
                begin
                    dx = pick_dir();
                    dy = pick_dir();
                    shoot(cx, cy, pick_pos(cx), pick_pos(cy), dx, dy);
                end
            end
        end
        start <= 1'b0;

        // Drain: wait for every cast, then keep the clock running to catch stray results.
        waited = 0;
        while (pending != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (400) @(posedge clk);

        $display("Sent %0d map writes and %0d casts over four pacing phases.",
                 write_count, cast_count);
        $display("Casts ended on %0d walls, %0d traps and %0d map exits.",
                 wall_count, trap_count, off_map_count);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
